// ===== rtl/waypoint_follower_mode_controller_top_defines.svh =====
// ----------------------------------------------------------------------------
// Waypoint follower mode controller assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_FOLLOWER_MODE_CONTROLLER_TOP_DEFINES_SVH
`define WAYPOINT_FOLLOWER_MODE_CONTROLLER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define WFMC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen outside reset
`define WFMC_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define WFMC_ASSERT(lbl, clk, rst, prop, msg)
`define WFMC_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== rtl/wfmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Waypoint follower mode controller package
// Shared constants, codes, state encoding, command/status bundles and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package wfmc_pkg;

   localparam int GOAL_DEPTH = 16;
   localparam int ATAN_ITER  = 16;
   localparam int HEAD_W     = $clog2(GOAL_DEPTH);
   localparam int CNT_W      = $clog2(GOAL_DEPTH + 1);
   localparam int SUM_W      = HEAD_W + 1;
   localparam int GOALS_W    = 5;
   localparam int GOAL_W     = 64;
   localparam int CW         = 40;
   localparam int ITER_W     = $clog2(ATAN_ITER);

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_CMD  = 2'd1,
      OP_GOAL = 2'd2,
      OP_POSE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CMD_GO    = 3'd0,
      CMD_STOP  = 3'd1,
      CMD_DRIVE = 3'd2,
      CMD_RESET = 3'd3,
      CMD_CLEAR = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_GO    = 2'd1,
      MODE_DRIVE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CSR_CRUISE = 2'd0,
      CSR_LIMIT  = 2'd1,
      CSR_RADIUS = 2'd2,
      CSR_GAIN   = 2'd3
   } csr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_TICK_SEL,
      S_RD_WAIT,
      S_MUL_X,
      S_MUL_Y,
      S_MUL_R,
      S_CMP,
      S_BR_INIT,
      S_NORM,
      S_ITER,
      S_ERR_MUL,
      S_CLAMP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load_item;
      logic store_cmd;
      logic push_goal;
      logic load_pose;
      logic apply_cmd;
      logic set_cruise;
      logic rd_goal;
      logic load_diff;
      logic mul_x;
      logic mul_y;
      logic mul_r;
      logic pop_goal;
      logic br_init;
      logic norm_step;
      logic iter_step;
      logic err_mul;
      logic clamp_out;
      logic write_rsp;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   mode_go;
      logic   drive_ready;
      logic   close;
      logic   br_zero;
      logic   norm_done;
      logic   iter_last;
      logic   rsp_free;
   } dp_stat_type;

   // atan(2^-i), 2^32 units per full turn
   function automatic logic [31:0] atan_tab(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458908;
         5'd3:  v = 32'd85004757;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/wfmc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wfmc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/wfmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Waypoint follower controller
// Sequences item handling, the arrival test and the iterative bearing unit.
// ----------------------------------------------------------------------------
`default_nettype none

module wfmc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire wfmc_pkg::dp_stat_type stat,
   output wfmc_pkg::dp_cmd_type      cmd
);

   import wfmc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req_valid) state_in = S_DECODE;
         S_DECODE:   state_in = (stat.op == OP_TICK) ? S_TICK_SEL : S_DONE;
         S_TICK_SEL: state_in = (!stat.mode_go && stat.drive_ready) ? S_RD_WAIT : S_DONE;
         S_RD_WAIT:  state_in = S_MUL_X;
         S_MUL_X:    state_in = S_MUL_Y;
         S_MUL_Y:    state_in = S_MUL_R;
         S_MUL_R:    state_in = S_CMP;
         S_CMP:      state_in = stat.close ? S_DONE : S_BR_INIT;
         S_BR_INIT:  state_in = stat.br_zero ? S_ERR_MUL : S_NORM;
         S_NORM:     if (stat.norm_done) state_in = S_ITER;
         S_ITER:     if (stat.iter_last) state_in = S_ERR_MUL;
         S_ERR_MUL:  state_in = S_CLAMP;
         S_CLAMP:    state_in = S_DONE;
         S_DONE:     if (stat.rsp_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         S_DECODE: begin
            case (stat.op)
               OP_CMD:  cmd.store_cmd = 1'b1;
               OP_GOAL: cmd.push_goal = 1'b1;
               OP_POSE: cmd.load_pose = 1'b1;
               default: cmd.apply_cmd = 1'b1;
            endcase
         end
         S_TICK_SEL: begin
            cmd.set_cruise = stat.mode_go;
            cmd.rd_goal    = !stat.mode_go && stat.drive_ready;
         end
         S_RD_WAIT:  cmd.load_diff = 1'b1;
         S_MUL_X:    cmd.mul_x = 1'b1;
         S_MUL_Y:    cmd.mul_y = 1'b1;
         S_MUL_R:    cmd.mul_r = 1'b1;
         S_CMP:      cmd.pop_goal = stat.close;
         S_BR_INIT:  cmd.br_init = 1'b1;
         S_NORM:     cmd.norm_step = !stat.norm_done;
         S_ITER:     cmd.iter_step = 1'b1;
         S_ERR_MUL:  cmd.err_mul = 1'b1;
         S_CLAMP:    cmd.clamp_out = 1'b1;
         S_DONE:     cmd.write_rsp = stat.rsp_free;
         default:    cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/wfmc_dp.sv =====
// ----------------------------------------------------------------------------
// Waypoint follower datapath
// Mode, pending command, pose, goal FIFO, arrival test, CORDIC bearing,
// steering rate and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "waypoint_follower_mode_controller_top_defines.svh"

module wfmc_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire wfmc_pkg::dp_cmd_type  cmd,
   output wfmc_pkg::dp_stat_type      stat,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [30:0]           csr_wdata,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [2:0]            req_cmd_code,
   input  wire logic [31:0]           req_pos_x,
   input  wire logic [31:0]           req_pos_y,
   input  wire logic [15:0]           req_heading,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_velocity_valid,
   output logic [14:0]                rsp_linear_speed,
   output logic [15:0]                rsp_angular_rate,
   output logic [1:0]                 rsp_mode,
   output logic [wfmc_pkg::GOALS_W-1:0] rsp_goals_waiting,
   output logic                       rsp_goal_dropped,
   output logic                       rsp_arrived
);

   import wfmc_pkg::*;

   // configuration
   logic [14:0] cruise_ff, limit_ff;
   logic [30:0] radius_ff;
   logic [15:0] gain_ff;

   // item
   op_type      op_ff, op_in;
   logic [2:0]  icmd_ff, icmd_in;
   logic [31:0] ix_ff, ix_in, iy_ff, iy_in;
   logic [15:0] ihd_ff, ihd_in;

   // control state
   mode_type          mode_ff, mode_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [2:0]        pend_cmd_ff, pend_cmd_in;
   logic [31:0]       pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;
   logic [15:0]       pose_hd_ff, pose_hd_in;
   logic [HEAD_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // working result
   logic        vv_ff, vv_in, drop_ff, drop_in, arr_ff, arr_in;
   logic [14:0] lin_ff, lin_in;
   logic [15:0] rate_ff, rate_in;

   // arrival test
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic        far_ff, far_in;
   logic [61:0] prod_ff, prod_in;
   logic [62:0] acc_ff, acc_in;

   // bearing
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [31:0]          ang_ff, ang_in;
   logic [ITER_W-1:0]    i_ff, i_in;
   logic signed [32:0]   eprod_ff, eprod_in;

   // result register
   logic                rv_ff, rv_in;
   logic                rvv_ff, rvv_in, rdrop_ff, rdrop_in, rarr_ff, rarr_in;
   logic [14:0]         rlin_ff, rlin_in;
   logic [15:0]         rrate_ff, rrate_in;
   logic [1:0]          rmode_ff, rmode_in;
   logic [GOALS_W-1:0]  rgoals_ff, rgoals_in;

   // goal store
   logic              ram_we;
   logic [HEAD_W-1:0] ram_waddr;
   logic [GOAL_W-1:0] ram_rdata;
   logic [SUM_W-1:0]  slot_sum;
   logic              full;

   // combinational helpers
   logic [32:0]          ax, ay;
   logic [30:0]          mul_a;
   logic [CW-1:0]        mag_x, mag_y;
   logic signed [CW-1:0] xs, ys, dx40, dy40;
   logic                 cy_pos;
   logic [31:0]          bsum;
   logic [15:0]          err;
   logic signed [33:0]   rnd;
   logic signed [17:0]   rate_full, lim18;

   function automatic logic [CW-1:0] mag40(input logic signed [CW-1:0] v);
      logic [CW-1:0] r;
      r = v[CW-1] ? CW'(-v) : CW'(v);
      return r;
   endfunction

   assign slot_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign ram_waddr = (slot_sum >= SUM_W'(GOAL_DEPTH)) ?
                      HEAD_W'(slot_sum - SUM_W'(GOAL_DEPTH)) : HEAD_W'(slot_sum);
   assign full      = (count_ff == CNT_W'(GOAL_DEPTH));
   assign ram_we    = cmd.push_goal && !full;

   wfmc_ram #(
      .WIDTH (GOAL_W),
      .DEPTH (GOAL_DEPTH)
   ) u_goal_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({ix_ff, iy_ff}),
      .re    (cmd.rd_goal),
      .raddr (head_ff),
      .rdata (ram_rdata)
   );

   assign ax    = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign ay    = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
   assign mul_a = cmd.mul_x ? ax[30:0] : (cmd.mul_y ? ay[30:0] : radius_ff);

   assign dx40   = CW'(dx_ff);
   assign dy40   = CW'(dy_ff);
   assign mag_x  = mag40(cx_ff);
   assign mag_y  = mag40(cy_ff);
   assign xs     = cx_ff >>> i_ff;
   assign ys     = cy_ff >>> i_ff;
   assign cy_pos = !cy_ff[CW-1] && (cy_ff != '0);

   assign bsum      = ang_ff + 32'h0000_8000;
   assign err       = bsum[31:16] - pose_hd_ff;
   assign rnd       = 34'(eprod_ff) + 34'sd32768;
   assign rate_full = rnd[33:16];
   assign lim18     = 18'(limit_ff);

   always_comb begin
      op_in = op_ff; icmd_in = icmd_ff; ix_in = ix_ff; iy_in = iy_ff; ihd_in = ihd_ff;
      mode_in = mode_ff; pend_valid_in = pend_valid_ff; pend_cmd_in = pend_cmd_ff;
      pose_x_in = pose_x_ff; pose_y_in = pose_y_ff; pose_hd_in = pose_hd_ff;
      head_in = head_ff; count_in = count_ff;
      vv_in = vv_ff; drop_in = drop_ff; arr_in = arr_ff; lin_in = lin_ff; rate_in = rate_ff;
      dx_in = dx_ff; dy_in = dy_ff; far_in = far_ff; acc_in = acc_ff;
      prod_in = 62'(mul_a) * 62'(mul_a);
      cx_in = cx_ff; cy_in = cy_ff; ang_in = ang_ff; i_in = i_ff; eprod_in = eprod_ff;

      if (cmd.load_item) begin
         op_in   = op_type'(req_opcode);
         icmd_in = req_cmd_code;
         ix_in   = req_pos_x;
         iy_in   = req_pos_y;
         ihd_in  = req_heading;
         vv_in   = (op_type'(req_opcode) == OP_TICK);
         drop_in = 1'b0;
         arr_in  = 1'b0;
         lin_in  = '0;
         rate_in = '0;
      end
      if (cmd.store_cmd) begin
         pend_valid_in = 1'b1;
         pend_cmd_in   = icmd_ff;
      end
      if (cmd.push_goal) begin
         if (full) begin
            drop_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.load_pose) begin
         pose_x_in  = ix_ff;
         pose_y_in  = iy_ff;
         pose_hd_in = ihd_ff;
      end
      if (cmd.apply_cmd && pend_valid_ff) begin
         pend_valid_in = 1'b0;
         case (pend_cmd_ff)
            CMD_GO:    if (mode_ff == MODE_IDLE) mode_in = MODE_GO;
            CMD_STOP:  mode_in = MODE_IDLE;
            CMD_DRIVE: if (mode_ff == MODE_IDLE) mode_in = MODE_DRIVE;
            CMD_RESET: begin
               head_in  = '0;
               count_in = '0;
               mode_in  = MODE_IDLE;
            end
            CMD_CLEAR: begin
               head_in  = '0;
               count_in = '0;
            end
            default: ;
         endcase
      end
      if (cmd.set_cruise) begin
         lin_in = cruise_ff;
      end
      if (cmd.load_diff) begin
         dx_in = 33'(signed'(ram_rdata[63:32])) - 33'(signed'(pose_x_ff));
         dy_in = 33'(signed'(ram_rdata[31:0])) - 33'(signed'(pose_y_ff));
      end
      if (cmd.mul_x) begin
         far_in = (ax[32:31] != 2'b00) || (ay[32:31] != 2'b00);
      end
      if (cmd.mul_y) begin
         acc_in = 63'(prod_ff);
      end
      if (cmd.mul_r) begin
         acc_in = acc_ff + 63'(prod_ff);
      end
      if (cmd.pop_goal) begin
         arr_in   = 1'b1;
         head_in  = (head_ff == HEAD_W'(GOAL_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (cmd.br_init) begin
         cx_in  = dx_ff[32] ? -dx40 : dx40;
         cy_in  = dx_ff[32] ? -dy40 : dy40;
         ang_in = dx_ff[32] ? 32'h8000_0000 : 32'h0;
         i_in   = '0;
      end
      if (cmd.norm_step) begin
         cx_in = cx_ff <<< 1;
         cy_in = cy_ff <<< 1;
      end
      if (cmd.iter_step) begin
         if (cy_pos) begin
            cx_in  = cx_ff + ys;
            cy_in  = cy_ff - xs;
            ang_in = ang_ff + atan_tab(5'(i_ff));
         end else begin
            cx_in  = cx_ff - ys;
            cy_in  = cy_ff + xs;
            ang_in = ang_ff - atan_tab(5'(i_ff));
         end
         i_in = i_ff + 1'b1;
      end
      if (cmd.err_mul) begin
         eprod_in = 33'(signed'(err)) * 33'(signed'({1'b0, gain_ff}));
      end
      if (cmd.clamp_out) begin
         lin_in = cruise_ff;
         if (rate_full > lim18) begin
            rate_in = 16'(lim18);
         end else if (rate_full < -lim18) begin
            rate_in = 16'(-lim18);
         end else begin
            rate_in = rate_full[15:0];
         end
      end
   end

   always_comb begin
      rv_in = rv_ff;
      rvv_in = rvv_ff; rlin_in = rlin_ff; rrate_in = rrate_ff; rmode_in = rmode_ff;
      rgoals_in = rgoals_ff; rdrop_in = rdrop_ff; rarr_in = rarr_ff;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      if (cmd.write_rsp) begin
         rv_in     = 1'b1;
         rvv_in    = vv_ff;
         rlin_in   = lin_ff;
         rrate_in  = rate_ff;
         rmode_in  = mode_ff;
         rgoals_in = GOALS_W'(count_ff);
         rdrop_in  = drop_ff;
         rarr_in   = arr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cruise_ff     <= 15'd410;
         limit_ff      <= 15'd1229;
         radius_ff     <= 31'd6554;
         gain_ff       <= 16'd25736;
         mode_ff       <= MODE_IDLE;
         pend_valid_ff <= 1'b0;
         pose_x_ff     <= '0;
         pose_y_ff     <= '0;
         pose_hd_ff    <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         rv_ff         <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_type'(csr_index))
               CSR_CRUISE: cruise_ff <= csr_wdata[14:0];
               CSR_LIMIT:  limit_ff  <= csr_wdata[14:0];
               CSR_RADIUS: radius_ff <= csr_wdata;
               CSR_GAIN:   gain_ff   <= csr_wdata[15:0];
               default: ;
            endcase
         end
         mode_ff       <= mode_in;
         pend_valid_ff <= pend_valid_in;
         pose_x_ff     <= pose_x_in;
         pose_y_ff     <= pose_y_in;
         pose_hd_ff    <= pose_hd_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         rv_ff         <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; icmd_ff <= icmd_in; ix_ff <= ix_in; iy_ff <= iy_in; ihd_ff <= ihd_in;
      pend_cmd_ff <= pend_cmd_in;
      vv_ff <= vv_in; drop_ff <= drop_in; arr_ff <= arr_in; lin_ff <= lin_in;
      rate_ff <= rate_in;
      dx_ff <= dx_in; dy_ff <= dy_in; far_ff <= far_in; prod_ff <= prod_in;
      acc_ff <= acc_in;
      cx_ff <= cx_in; cy_ff <= cy_in; ang_ff <= ang_in; i_ff <= i_in;
      eprod_ff <= eprod_in;
      rvv_ff <= rvv_in; rlin_ff <= rlin_in; rrate_ff <= rrate_in; rmode_ff <= rmode_in;
      rgoals_ff <= rgoals_in; rdrop_ff <= rdrop_in; rarr_ff <= rarr_in;
   end

   always_comb begin
      stat.op          = op_ff;
      stat.mode_go     = (mode_ff == MODE_GO);
      stat.drive_ready = (mode_ff == MODE_DRIVE) && (count_ff != '0);
      stat.close       = !far_ff && (acc_ff < 63'(prod_ff));
      stat.br_zero     = (dx_ff == '0) && (dy_ff == '0);
      stat.norm_done   = (mag_x[CW-1:32] != '0) || (mag_y[CW-1:32] != '0);
      stat.iter_last   = (i_ff == ITER_W'(ATAN_ITER - 1));
      stat.rsp_free    = !rv_ff || rsp_ready;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_velocity_valid = rvv_ff;
   assign rsp_linear_speed   = rlin_ff;
   assign rsp_angular_rate   = rrate_ff;
   assign rsp_mode           = rmode_ff;
   assign rsp_goals_waiting  = rgoals_ff;
   assign rsp_goal_dropped   = rdrop_ff;
   assign rsp_arrived        = rarr_ff;

   `WFMC_NEVER(a_pop_empty, clock, reset, cmd.pop_goal && (count_ff == '0), "pop on empty FIFO")
   `WFMC_NEVER(a_cnt_over, clock, reset, count_ff > CNT_W'(GOAL_DEPTH), "goal count over depth")
   `WFMC_ASSERT(a_rsp_load, clock, reset, cmd.write_rsp |=> rv_ff, "result not held")
   `WFMC_NEVER(a_rsp_clobber, clock, reset, cmd.write_rsp && rv_ff && !rsp_ready, "result lost")

endmodule

`default_nettype wire

// ===== rtl/waypoint_follower_mode_controller_top.sv =====
// ----------------------------------------------------------------------------
// Waypoint follower mode controller
// Mode and goal FIFO handling with proportional heading steering.
// ----------------------------------------------------------------------------
//  channel | ports                      | direction
//  req     | req_valid/req_ready + item | in
//  rsp     | rsp_valid/rsp_ready + item | out
//  csr     | csr_we, csr_index, csr_wdata | in, write only
//
//  A tick in idle or go mode does not steer. In drive mode with goals waiting
//  a tick runs the arrival test on the shared squaring multiplier and, unless
//  the goal is reached, steers: the normalize loop does one doubling per cycle
//  and the CORDIC unit one iteration per cycle (16 iterations).
//  Reset is synchronous; it clears mode, pending command, pose, the FIFO and
//  a waiting result, and restores the configuration defaults.
//  One transaction is in work at a time; a waiting result holds the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_follower_mode_controller_top (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_opcode,
   input  wire logic [2:0]               req_cmd_code,
   input  wire logic [31:0]              req_pos_x,
   input  wire logic [31:0]              req_pos_y,
   input  wire logic [15:0]              req_heading,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_velocity_valid,
   output logic [14:0]                   rsp_linear_speed,
   output logic [15:0]                   rsp_angular_rate,
   output logic [1:0]                    rsp_mode,
   output logic [wfmc_pkg::GOALS_W-1:0]  rsp_goals_waiting,
   output logic                          rsp_goal_dropped,
   output logic                          rsp_arrived,
   input  wire logic                     csr_we,
   input  wire logic [1:0]               csr_index,
   input  wire logic [30:0]              csr_wdata
);

   import wfmc_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   wfmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wfmc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_opcode         (req_opcode),
      .req_cmd_code       (req_cmd_code),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_heading        (req_heading),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_velocity_valid (rsp_velocity_valid),
      .rsp_linear_speed   (rsp_linear_speed),
      .rsp_angular_rate   (rsp_angular_rate),
      .rsp_mode           (rsp_mode),
      .rsp_goals_waiting  (rsp_goals_waiting),
      .rsp_goal_dropped   (rsp_goal_dropped),
      .rsp_arrived        (rsp_arrived)
   );

endmodule

`default_nettype wire
